/* rtl/nsss_pkg.sv */
// ----------------------------------------------------------------------------
// nsss_pkg
// Shared types and command codes for the sorting cell chain.
// ----------------------------------------------------------------------------
package nsss_pkg;

	localparam int DATA_W = 32;

	// cell commands
	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_SHIFT  = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] data;
	} cell_cmd_t;

endpackage

/* rtl/nsss_cell.sv */
// ----------------------------------------------------------------------------
// nsss_cell
// One slot of the sorted chain: holds a value, keeps it, takes the new
// value, or takes a neighbor's value on shift and insert.
// ----------------------------------------------------------------------------
module nsss_cell
	import nsss_pkg::*;
(
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic                     occ,
	input  logic signed [DATA_W-1:0] left_value,
	input  logic                     left_stay,
	input  logic signed [DATA_W-1:0] right_value,
	output logic signed [DATA_W-1:0] value,
	output logic                     stay
);

	logic signed [DATA_W-1:0] value_q;

	// an occupied slot not above the new value keeps its place on insert
	assign stay  = occ && (value_q <= cmd.data);
	assign value = value_q;

	// slot update
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SHIFT: begin
				value_q <= right_value;
			end
			OP_INSERT: begin
				if (!stay) begin
					value_q <= left_stay ? cmd.data : left_value;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/nearly_sorted_stream_sorter.sv */
// ----------------------------------------------------------------------------
// nearly_sorted_stream_sorter
// Window sorter for a nearly sorted stream, built as a sorted chain of cells
// holding up to min(window_extent + 1, CAPACITY) values; drains on last item.
// ----------------------------------------------------------------------------
// order: the emitted minimum is loaded into the output register in the pop
//   step after its item's accept, once the output register is free; on a
//   last item the drain loads its first result after the insert step
// sequence: each item passes the accept, pop and insert steps before the next
//   is taken; the drain gives one result per cycle while output slot is free
// reset: occupancy clears to zero and window_extent to one; cell contents
//   stay undefined until written, and no clearing pass is run
// ----------------------------------------------------------------------------
module nearly_sorted_stream_sorter
	import nsss_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// input items
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [DATA_W-1:0]        s_axis_tdata,  // [31:0] value
	input  logic                     s_axis_tlast,  // last
	// result items
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [DATA_W-1:0]        m_axis_tdata,  // [31:0] value_res
	output logic                     m_axis_tlast   // last_res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > 6) ? CW : 6;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_POP   = 2'd1;
	localparam logic [1:0] ST_INS   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	localparam logic REG_WINDOW = 1'b0;

	logic [4:0]               window_extent_q;
	logic [1:0]               state_q, state_d;
	logic [CW-1:0]            count_q, count_d;
	logic signed [DATA_W-1:0] item_value_q;
	logic                     item_last_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_data_q;
	logic                     out_last_q;

	cell_cmd_t                cmd;
	logic                     load, load_last;
	logic                     slot_free, need_pop;
	logic [LW-1:0]            limit, window_plus, count_ext;

	logic signed [DATA_W-1:0] cell_value [CAPACITY];
	logic                     cell_stay  [CAPACITY];
	logic [CAPACITY-1:0]      occ;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WINDOW) ? {27'd0, window_extent_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_extent_q <= 5'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW) begin
			window_extent_q <= pwdata[4:0];
		end
	end

	// occupancy limit, capped at the chain length
	assign window_plus = LW'(window_extent_q) + LW'(1);
	assign limit       = (window_plus > LW'(CAPACITY)) ? LW'(CAPACITY) : window_plus;
	assign count_ext   = LW'(count_q);
	assign need_pop    = (count_ext >= limit) && (count_q != '0);
	assign slot_free   = !out_valid_q || m_axis_tready;

	// sequencer
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cmd.op    = OP_HOLD;
		cmd.data  = item_value_q;
		load      = 1'b0;
		load_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (!need_pop) begin
					state_d = ST_INS;
				end else if (slot_free) begin
					load    = 1'b1;
					cmd.op  = OP_SHIFT;
					count_d = count_q - CW'(1);
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				cmd.op  = OP_INSERT;
				count_d = count_q + CW'(1);
				state_d = item_last_q ? ST_DRAIN : ST_IDLE;
			end
			ST_DRAIN: begin
				if (slot_free) begin
					load      = 1'b1;
					load_last = (count_q == CW'(1));
					cmd.op    = OP_SHIFT;
					count_d   = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// input item capture
	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_value_q <= $signed(s_axis_tdata);
			item_last_q  <= s_axis_tlast;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= cell_value[0];
			out_last_q <= load_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// sorted cell chain, minimum at the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_value, right_value;
		logic                     left_stay;

		assign occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_value = '0;
			assign left_stay  = 1'b1;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_stay  = cell_stay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
		end

		nsss_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occ         (occ[i]),
			.left_value  (left_value),
			.left_stay   (left_stay),
			.right_value (right_value),
			.value       (cell_value[i]),
			.stay        (cell_stay[i])
		);
	end

	// occupancy never exceeds the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	// an insert always finds a free slot
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> count_q < CW'(CAPACITY))
		else $error("insert into full chain");

	// the head pair of the chain stays in order
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> cell_value[0] <= cell_value[1])
		else $error("chain head out of order");

	// the final drain result leaves the chain empty
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load && load_last |=> count_q == '0)
		else $error("chain not empty after drain");

endmodule
